[hdl/ssbfir_pkg.sv]
// Shared constants and controller/datapath interface types for the SSB FIR.
`timescale 1ns / 1ps
package ssbfir_pkg;

  localparam int MAX_TAPS    = 64;
  localparam int ADDR_W      = $clog2(MAX_TAPS);
  localparam int NT_W        = 7;
  localparam int STEP_W      = $clog2(MAX_TAPS / 2);
  localparam int PAIR_W      = STEP_W + 1;
  localparam int SAMPLE_BITS = 16;
  localparam int COEF_BITS   = 16;
  localparam int PROD_W      = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_W       = 40;

  localparam logic [NT_W-1:0] NT_RESET = NT_W'(MAX_TAPS);

  localparam logic CMD_FILTER = 1'b0;
  localparam logic CMD_COEF   = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic              sample_wr;
    logic              coef_wr;
    logic              issue;
    logic [STEP_W-1:0] step;
    logic [NT_W-1:0]   n_taps;
    logic              load_out;
  } ctrl_cmd_t;

  // Status from the datapath back to the controller
  typedef struct packed {
    logic out_full;
  } dp_sts_t;

endpackage

[hdl/ssb_interleaved_fir.sv]
// Top level of the single-sideband interleaved-tap FIR filter.
// A sample request runs one pass with the I/Q MAC pair walking two taps a cycle, then loads the
// result register; out_tvalid rises once it is loaded. No new request is taken until the pass
// ends, and a full result register holds the pass back. Coefficient requests give no result.
// Reset (rst_n, synchronous, active low): num_taps 64, delay fill count and coefficient valid
// bits cleared so all taps read as zero; no clearing pass is needed.
`timescale 1ns / 1ps
module ssb_interleaved_fir import ssbfir_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  // input request channel
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [39:0]         in_tdata,   // sample[15:0], coef_index[21:16], coef_value[37:22]
  input  logic                in_tuser,   // cmd[0]
  // result channel
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [2*ACC_W-1:0]  out_tdata,  // out_i[39:0], out_q[79:40]
  // num_taps write port
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [NT_W-1:0]     cfg_data
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  // unpack request fields
  logic signed [SAMPLE_BITS-1:0] sample;
  logic [ADDR_W-1:0]             coef_index;
  logic signed [COEF_BITS-1:0]   coef_value;

  assign sample     = in_tdata[15:0];
  assign coef_index = in_tdata[21:16];
  assign coef_value = in_tdata[37:22];

  // sequencer: decodes requests, holds num_taps, steps tap pairs and drains the pipe
  ssbfir_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts)
  );

  // datapath: ring buffer + coefficient RAM, read -> multiply -> accumulate,
  // then a result register so the next request is taken while a result waits
  ssbfir_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .sample     (sample),
    .coef_index (coef_index),
    .coef_value (coef_value),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

[hdl/ssbfir_dp.sv]
// Datapath: sample ring buffer, coefficient store, two MAC lanes, result register.
`timescale 1ns / 1ps
module ssbfir_dp import ssbfir_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ctrl_cmd_t                     cmd,
  output dp_sts_t                       sts,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic [ADDR_W-1:0]             coef_index,
  input  logic signed [COEF_BITS-1:0]   coef_value,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [2*ACC_W-1:0]            out_tdata
);

  logic signed [SAMPLE_BITS-1:0] dly_mem [MAX_TAPS];
  logic signed [COEF_BITS-1:0]   coef_mem [MAX_TAPS];
  logic [MAX_TAPS-1:0]           coef_vld_r;
  logic [ADDR_W-1:0]             wptr_r;
  logic [NT_W-1:0]               fill_r;

  logic [ADDR_W-1:0] k_e, k_o, rd_e, rd_o;
  logic [NT_W-1:0]   age_e, age_o, k_o_ext;
  logic              use_e, use_o;

  logic signed [SAMPLE_BITS-1:0] s_e_r, s_o_r;
  logic signed [COEF_BITS-1:0]   c_e_r, c_o_r;
  logic                          use_e_r, use_o_r;
  logic signed [PROD_W-1:0]      prod_e_r, prod_o_r;
  logic signed [ACC_W-1:0]       acc_i_r, acc_q_r;
  logic                          out_valid_r;
  logic [2*ACC_W-1:0]            out_data_r;

  // tap addresses for pair step j: even tap 2j, odd tap 2j+1
  assign k_e     = {cmd.step, 1'b0};
  assign k_o     = {cmd.step, 1'b1};
  assign k_o_ext = {1'b0, k_o};
  // newest sample sits at wptr-1; tap k reads age n-1-k
  assign rd_e    = wptr_r - cmd.n_taps[ADDR_W-1:0] + k_e;
  assign rd_o    = rd_e + ADDR_W'(1);
  assign age_e   = cmd.n_taps - NT_W'(1) - {1'b0, k_e};
  assign age_o   = age_e - NT_W'(1);
  // samples older than the fill count were never written, so those taps are masked to zero
  assign use_e   = cmd.issue && (age_e < fill_r) && coef_vld_r[k_e];
  assign use_o   = cmd.issue && (k_o_ext < cmd.n_taps) && (age_o < fill_r)
                   && coef_vld_r[k_o];

  always_ff @(posedge clk) begin
    if (cmd.sample_wr) begin
      dly_mem[wptr_r] <= sample;
    end
    if (cmd.coef_wr) begin
      coef_mem[coef_index] <= coef_value;
    end
  end

  always_ff @(posedge clk) begin
    s_e_r <= dly_mem[rd_e];
    s_o_r <= dly_mem[rd_o];
    c_e_r <= coef_mem[k_e];
    c_o_r <= coef_mem[k_o];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_vld_r <= '0;
      wptr_r     <= '0;
      fill_r     <= '0;
      use_e_r    <= 1'b0;
      use_o_r    <= 1'b0;
    end else begin
      use_e_r <= use_e;
      use_o_r <= use_o;
      if (cmd.coef_wr) begin
        coef_vld_r[coef_index] <= 1'b1;
      end
      if (cmd.sample_wr) begin
        wptr_r <= wptr_r + ADDR_W'(1);
        if (fill_r < NT_W'(MAX_TAPS)) begin
          fill_r <= fill_r + NT_W'(1);
        end
      end
    end
  end

  // multiply stage, unused lanes give zero
  always_ff @(posedge clk) begin
    prod_e_r <= use_e_r ? PROD_W'(s_e_r * c_e_r) : '0;
    prod_o_r <= use_o_r ? PROD_W'(s_o_r * c_o_r) : '0;
  end

  always_ff @(posedge clk) begin
    if (cmd.sample_wr) begin
      acc_i_r <= '0;
      acc_q_r <= '0;
    end else begin
      acc_i_r <= acc_i_r + ACC_W'(prod_e_r);
      acc_q_r <= acc_q_r + ACC_W'(prod_o_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r <= {acc_q_r, acc_i_r};
    end
  end

  assign sts.out_full = out_valid_r && !out_tready;
  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;

endmodule

[hdl/ssbfir_ctrl.sv]
// Controller: request decode, num_taps register and tap-pair sequencer.
`timescale 1ns / 1ps
module ssbfir_ctrl import ssbfir_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic            in_tuser,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [NT_W-1:0] cfg_data,
  output ctrl_cmd_t       cmd,
  input  dp_sts_t         sts
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_RUN   = 4'b0010,
    S_DRAIN = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  logic [NT_W-1:0]   num_taps_r;
  logic [NT_W-1:0]   n_eff;
  logic [PAIR_W-1:0] pairs;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              drain_r, drain_nxt;
  logic              acc_req;

  assign n_eff   = (num_taps_r > NT_W'(MAX_TAPS)) ? NT_W'(MAX_TAPS) : num_taps_r;
  assign pairs   = PAIR_W'((n_eff + NT_W'(1)) >> 1);
  assign acc_req = in_tvalid && in_tready;

  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    drain_nxt = drain_r;
    unique case (state_r)
      S_IDLE: begin
        step_nxt  = '0;
        drain_nxt = 1'b0;
        if (acc_req && (in_tuser == CMD_FILTER)) begin
          state_nxt = (pairs == '0) ? S_DRAIN : S_RUN;
        end
      end
      S_RUN: begin
        if ({1'b0, step_r} == pairs - PAIR_W'(1)) begin
          state_nxt = S_DRAIN;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      S_DRAIN: begin
        drain_nxt = 1'b1;
        if (drain_r) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!sts.out_full) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      step_r     <= '0;
      drain_r    <= 1'b0;
      num_taps_r <= NT_RESET;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      drain_r <= drain_nxt;
      if (cfg_valid && cfg_ready) begin
        num_taps_r <= cfg_data;
      end
    end
  end

  assign cmd.sample_wr = acc_req && (in_tuser == CMD_FILTER);
  assign cmd.coef_wr   = acc_req && (in_tuser == CMD_COEF);
  assign cmd.issue     = (state_r == S_RUN);
  assign cmd.step      = step_r;
  assign cmd.n_taps    = n_eff;
  assign cmd.load_out  = (state_r == S_DONE) && !sts.out_full;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.load_out && sts.out_full))
    else $error("result register loaded while still full");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> ({1'b0, step_r} < pairs))
    else $error("tap-pair step beyond pair count");

  a_sample_starts: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sample_wr |=> (state_r == S_RUN || state_r == S_DRAIN))
    else $error("sample request did not start a pass");

  a_done_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !sts.out_full) |=> (state_r == S_IDLE))
    else $error("finished pass did not return to idle");
`endif

endmodule

[tb/sv/ssb_fir_checker.sv]
// Checker for the SSB FIR: watches all three channels, predicts I/Q sums and compares results.
`timescale 1ns / 1ps
module ssb_fir_checker import ssbfir_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  logic               in_tready,
  input  logic [39:0]        in_tdata,   // sample[15:0], coef_index[21:16], coef_value[37:22]
  input  logic               in_tuser,   // cmd[0]
  input  logic               out_tvalid,
  input  logic               out_tready,
  input  logic [2*ACC_W-1:0] out_tdata,  // out_i[39:0], out_q[79:40]
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [NT_W-1:0]    cfg_data,
  output int                 fail_count,
  output int                 pending,
  output int                 n_samples,
  output int                 n_coefs,
  output int                 n_results
);

  typedef struct packed {
    logic [ACC_W-1:0] i;
    logic [ACC_W-1:0] q;
  } iq_t;

  logic signed [SAMPLE_BITS-1:0] sample_hist [MAX_TAPS];
  logic signed [COEF_BITS-1:0]   coef_mem    [MAX_TAPS];
  logic [NT_W-1:0]               tap_count;
  iq_t                           iq_expected [$];

  int fails     = 0;
  int samples   = 0;
  int coefs     = 0;
  int results   = 0;

  // Even taps into I, odd taps into Q; tap k meets the sample n-1-k steps old
  function automatic iq_t iq_sums(input logic [NT_W-1:0] taps);
    int                 n;
    int                 k;
    logic signed [63:0] acc_i;
    logic signed [63:0] acc_q;
    logic signed [63:0] prod;
    iq_t                r;
    n     = (taps > MAX_TAPS) ? MAX_TAPS : int'(taps);
    acc_i = '0;
    acc_q = '0;
    for (k = 0; k < n; k++) begin
      prod = sample_hist[n-1-k] * coef_mem[k];
      if (k % 2 == 0) acc_i += prod;
      else            acc_q += prod;
    end
    r.i = acc_i[ACC_W-1:0];
    r.q = acc_q[ACC_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    iq_t got;
    iq_t want;
    int  k;
    if (!rst_n) begin
      for (k = 0; k < MAX_TAPS; k++) begin
        sample_hist[k] = '0;
        coef_mem[k]    = '0;
      end
      tap_count = NT_RESET;
      iq_expected.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.i = out_tdata[ACC_W-1:0];
        got.q = out_tdata[2*ACC_W-1:ACC_W];
        results++;
        if (iq_expected.size() == 0) begin
          fails++;
          $error("out_tdata: result with no request waiting, out_i %0d out_q %0d",
                 $signed(got.i), $signed(got.q));
        end else begin
          want = iq_expected.pop_front();
          if (got.i !== want.i) begin
            fails++;
            $error("out_i: expected %0d, actual %0d", $signed(want.i), $signed(got.i));
          end
          if (got.q !== want.q) begin
            fails++;
            $error("out_q: expected %0d, actual %0d", $signed(want.q), $signed(got.q));
          end
        end
      end
      if (cfg_valid && cfg_ready) tap_count = cfg_data;
      if (in_tvalid && in_tready) begin
        if (in_tuser == CMD_COEF) begin
          coef_mem[in_tdata[21:16]] = in_tdata[37:22];
          coefs++;
        end else begin
          for (k = MAX_TAPS - 1; k > 0; k--) sample_hist[k] = sample_hist[k-1];
          sample_hist[0] = in_tdata[15:0];
          iq_expected.push_back(iq_sums(tap_count));
          samples++;
        end
      end
    end
    fail_count <= fails;
    pending    <= iq_expected.size();
    n_samples  <= samples;
    n_coefs    <= coefs;
    n_results  <= results;
  end

endmodule

[tb/sv/testbench.sv]
// Top of the SSB FIR testbench: clock, reset, stimulus, result back-pressure and verdict.
`timescale 1ns / 1ps
module testbench;
  import ssbfir_pkg::*;

  // Longest quiet spell the run tolerates: several times the worst of a
  // full pass, a sender gap, a receiver stall and the long hold-off.
  localparam int IDLE_LIMIT   = 2000;
  // Covers the worst pass, at 64 taps, with a little margin on top
  localparam int DRAIN_CYCLES = 40;
  // Long receiver hold-off, enough to back the block up into its input
  localparam int HOLD_CYCLES  = 400;
  localparam int RANDOM_ITEMS = 520;

  localparam logic [15:0] Q15_MAX = 16'h7FFF;
  localparam logic [15:0] Q15_MIN = 16'h8000;
  localparam logic [15:0] Q15_M1  = 16'hFFFF;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [39:0]        in_tdata;   // sample[15:0], coef_index[21:16], coef_value[37:22]
  logic               in_tuser;   // cmd[0]
  logic               out_tvalid;
  logic               out_tready;
  logic [2*ACC_W-1:0] out_tdata;  // out_i[39:0], out_q[79:40]
  logic               cfg_valid;
  logic               cfg_ready;
  logic [NT_W-1:0]    cfg_data;

  int fail_count;
  int pending;
  int n_samples;
  int n_coefs;
  int n_results;

  int   requests_sent = 0;
  int   tap_writes    = 0;
  int   burst_left    = 0;
  int   quiet_cycles  = 0;
  logic hold_go       = 1'b0;
  logic hold_done     = 1'b0;

  always #4 clk = ~clk;

  ssb_interleaved_fir i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  ssb_fir_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending),
    .n_samples  (n_samples),
    .n_coefs    (n_coefs),
    .n_results  (n_results)
  );

  // --- sender helpers -------------------------------------------------

  // Present one request at the falling edge and hold it until accepted.
  // Returns just after the accepting rising edge, valid still high, so a
  // following request goes out back to back.
  task automatic send_request(input logic cmd, input logic [15:0] smp,
                              input logic [5:0] idx, input logic [15:0] val);
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser  = cmd;
    in_tdata  = {2'b00, val, idx, smp};
    do @(posedge clk); while (!in_tready);
    requests_sent++;
  endtask

  task automatic sender_idle();
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  // Bursts of random length; between bursts valid drops unless no_gaps is set
  task automatic pace(input bit no_gaps);
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 16);
      gap = no_gaps ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        sender_idle();
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  task automatic wait_results();
    while (pending != 0) @(posedge clk);
  endtask

  // Tap count only changes with the block idle: all results in, then a full
  // pass worth of cycles in case a coefficient request is still settling.
  task automatic write_taps(input logic [NT_W-1:0] n);
    sender_idle();
    wait_results();
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = n;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    tap_writes++;
  endtask

  // Mostly random, with the Q1.15 extremes and zero turning up often
  function automatic logic [15:0] q15_pick();
    case ($urandom_range(0, 7))
      0:       return Q15_MIN;
      1:       return Q15_MAX;
      2:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // --- stimulus -------------------------------------------------------

  initial begin : stimulus
    int              tap_plan [8];
    int              phase;
    int              count;
    int              k;
    bit              no_gaps;
    logic [NT_W-1:0] taps;
    logic            cmd;

    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = CMD_FILTER;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    tap_plan  = '{1, 0, 2, 3, 64, 63, 65, 127};

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: coefficient extremes at both ends of the store, sample
    // extremes, then zero taps, a single tap, an over-range count and a
    // change of count reusing the history already in the delay line.
    send_request(CMD_COEF,   16'h0000, 6'd0,  Q15_MAX);
    send_request(CMD_COEF,   16'h0000, 6'd63, Q15_MIN);
    send_request(CMD_COEF,   16'h0000, 6'd1,  Q15_MIN);
    send_request(CMD_COEF,   16'h0000, 6'd62, Q15_MAX);
    send_request(CMD_COEF,   16'h0000, 6'd31, Q15_M1);
    send_request(CMD_FILTER, Q15_MAX,  6'd0,  16'h0000);
    send_request(CMD_FILTER, Q15_MIN,  6'd63, Q15_M1);
    send_request(CMD_FILTER, 16'h0000, 6'd0,  16'h0000);
    send_request(CMD_FILTER, Q15_M1,   6'd0,  16'h0000);
    send_request(CMD_FILTER, 16'h0001, 6'd0,  16'h0000);
    write_taps(7'd0);
    send_request(CMD_FILTER, Q15_MAX,  6'd0,  16'h0000);
    send_request(CMD_FILTER, Q15_MIN,  6'd0,  16'h0000);
    write_taps(7'd1);
    send_request(CMD_FILTER, Q15_MIN,  6'd0,  16'h0000);
    send_request(CMD_FILTER, Q15_MAX,  6'd0,  16'h0000);
    write_taps(7'd127);
    send_request(CMD_FILTER, Q15_MAX,  6'd0,  16'h0000);
    send_request(CMD_FILTER, Q15_MIN,  6'd0,  16'h0000);
    write_taps(7'd2);
    send_request(CMD_FILTER, Q15_M1,   6'd0,  16'h0000);

    // Random phases, one tap count each; the first few walk the extremes
    phase = 0;
    while (requests_sent < RANDOM_ITEMS) begin
      if (phase < 8)
        taps = NT_W'(tap_plan[phase]);
      else if ($urandom_range(0, 3) == 0)
        taps = NT_W'($urandom_range(0, 127));
      else
        taps = NT_W'($urandom_range(1, 64));
      write_taps(taps);
      no_gaps    = ($urandom_range(0, 3) == 0);
      burst_left = $urandom_range(1, 16);

      if (phase == 4) begin
        // Largest sums: every coefficient and sample at the negative
        // extreme, then positive samples for the most negative sums
        for (k = 0; k < MAX_TAPS; k++) begin
          send_request(CMD_COEF, q15_pick(), 6'(k), Q15_MIN);
          pace(no_gaps);
        end
        for (k = 0; k < 110; k++) begin
          send_request(CMD_FILTER, (k < 70) ? Q15_MIN : Q15_MAX, 6'($urandom),
                       16'($urandom));
          pace(no_gaps);
        end
      end else begin
        // The receiver starts its long hold-off while this phase streams
        if (phase == 2) hold_go = 1'b1;
        count = $urandom_range(30, 60);
        for (k = 0; k < count; k++) begin
          cmd = ($urandom_range(0, 99) < 25) ? CMD_COEF : CMD_FILTER;
          send_request(cmd, q15_pick(), 6'($urandom_range(0, 63)), q15_pick());
          pace(no_gaps);
        end
      end
      phase++;
    end

    // Drain, then one more pass worth of cycles for stray results
    sender_idle();
    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run: %0d requests (%0d samples, %0d coefficient writes), %0d results checked.",
             requests_sent, n_samples, n_coefs, n_results);
    $display("Tap count written %0d times over %0d random phases, incl. 0, 1, 64 and 127.",
             tap_writes, phase);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // --- result back-pressure -------------------------------------------

  // Own stall pattern in segments: always ready, mostly ready, or coin
  // toss; one long hold-off once the sender flags the chosen phase.
  initial begin : receiver
    int mode;
    int seg;
    int c;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      mode = $urandom_range(0, 2);
      seg  = $urandom_range(20, 200);
      for (c = 0; c < seg; c++) begin
        @(negedge clk);
        if (hold_go && !hold_done) begin
          out_tready = 1'b0;
          repeat (HOLD_CYCLES) @(negedge clk);
          hold_done = 1'b1;
        end
        case (mode)
          0:       out_tready = 1'b1;
          1:       out_tready = ($urandom_range(0, 3) != 0);
          default: out_tready = 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  // --- watchdog -------------------------------------------------------

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no request or result moved for %0d cycles.", IDLE_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

endmodule

[filelist.f]
hdl/ssbfir_pkg.sv
hdl/ssbfir_dp.sv
hdl/ssbfir_ctrl.sv
hdl/ssb_interleaved_fir.sv
tb/sv/ssb_fir_checker.sv
tb/sv/testbench.sv
